// ===== rtl/amrdf_pkg.sv =====
`default_nettype none

package amrdf_pkg;

  localparam int COUNT_BITS = 24;
  localparam int LEFT_BITS  = 5;

  localparam logic [7:0] FILL_BYTE = 8'hFF;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [1:0] {
    ST_FRAME   = 2'd0,
    ST_END     = 2'd1,
    ST_TRUNC   = 2'd2,
    ST_ABANDON = 2'd3
  } status_t;

  typedef enum logic {
    REG_BAD_HEADER_LIMIT = 1'b0
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_start;
    logic       frame_last;
    status_t    status;
  } out_beat_t;

  typedef struct packed {
    logic                  in_payload;
    logic [LEFT_BITS-1:0]  payload_left;
    logic [COUNT_BITS-1:0] bad_header_count;
  } parse_state_t;

  // Payload length in bytes after the header, by frame type
  function automatic logic [LEFT_BITS-1:0] frame_len(input logic [3:0] ft);
    logic [LEFT_BITS-1:0] len;
    case (ft)
      4'd0:    len = LEFT_BITS'(12);
      4'd1:    len = LEFT_BITS'(13);
      4'd2:    len = LEFT_BITS'(15);
      4'd3:    len = LEFT_BITS'(17);
      4'd4:    len = LEFT_BITS'(19);
      4'd5:    len = LEFT_BITS'(20);
      4'd6:    len = LEFT_BITS'(26);
      4'd7:    len = LEFT_BITS'(31);
      4'd8:    len = LEFT_BITS'(5);
      default: len = '0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/amr_frame_deframer_core.sv =====
`default_nettype none

// AMR-NB storage-format deframer.
// Input channel (in_valid / in_stall / in_data): one stream byte per beat, or
// an end-of-data beat. Output channel (out_valid / out_stall / out_data): one
// header or payload byte per beat with start and last marks, or a status beat
// (end of stream, truncated frame, search abandoned). Fill bytes give no output
// beat; corrupt header bytes give none until their count reaches the limit.
// An accepted beat is held in the input register, parsed, and registered in
// the output register, from which the receiver takes it. Throughput: one beat
// per cycle; the input register, the parse logic and the output register form
// a two-stage pipeline that moves on every cycle the output register is free.
// When the receiver stalls, the output beat holds, the parse stage holds its
// beat and in_stall rises in the same cycle once the parse stage holds one.
// Reset (rst, synchronous): pipeline empty, header search, bad-header count
// zero, bad_header_limit all ones. The limit register sits at APB address 0;
// write it only while the block is idle.
module amr_frame_deframer_core
  import amrdf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_beat_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_beat_t        out_data
);

  logic [COUNT_BITS-1:0] limit;
  logic                  cfg_wr;
  reg_idx_t              cfg_idx;

  logic         stage_valid;
  in_beat_t     stage_beat;
  logic         advance;
  parse_state_t state;
  parse_state_t state_next;
  logic         res_valid;
  out_beat_t    res;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_BAD_HEADER_LIMIT: prdata = 32'(limit);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= COUNT_MAX;
    end else if (cfg_wr && cfg_idx == REG_BAD_HEADER_LIMIT) begin
      limit <= pwdata[COUNT_BITS-1:0];
    end
  end

  // parse stage moves when the output register is empty or being drained
  assign advance  = stage_valid && (!out_valid || !out_stall);
  assign in_stall = stage_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!in_stall) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stage_beat <= in_data;
    end
  end

  amrdf_step u_step (
    .limit     (limit),
    .cur       (state),
    .beat      (stage_beat),
    .nxt       (state_next),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_data <= res;
    end
  end

`ifndef SYNTH
  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    state.in_payload == (state.payload_left != '0))
    else $error("payload flag and remaining count disagree");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_FRAME |->
      out_data.frame_byte == '0 && !out_data.frame_start && !out_data.frame_last)
    else $error("status beat carries frame bits");

  a_stall_needs_stage: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> stage_valid && out_valid && out_stall)
    else $error("input stalled with free pipeline");

  a_start_leaves_search: assert property (@(posedge clk) disable iff (rst)
    advance && res_valid && res.frame_start |=>
      state.bad_header_count == '0)
    else $error("bad-header count not cleared on header");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("parse state moved without a beat");
`endif

endmodule

`default_nettype wire

// ===== rtl/amrdf_step.sv =====
`default_nettype none

module amrdf_step
  import amrdf_pkg::*;
(
  input  wire logic [COUNT_BITS-1:0] limit,
  input  wire parse_state_t          cur,
  input  wire in_beat_t              beat,
  output parse_state_t               nxt,
  output logic                       res_valid,
  output out_beat_t                  res
);

  logic [COUNT_BITS-1:0] limit_eff;
  logic [COUNT_BITS-1:0] count_inc;
  logic [LEFT_BITS-1:0]  left_dec;
  logic [LEFT_BITS-1:0]  len;

  assign limit_eff = (limit == '0) ? COUNT_BITS'(1) : limit;
  assign count_inc = (cur.bad_header_count == COUNT_MAX) ? COUNT_MAX
                                                         : cur.bad_header_count + 1'b1;
  assign left_dec  = (cur.payload_left != '0) ? cur.payload_left - 1'b1 : '0;
  assign len       = frame_len(beat.data_byte[6:3]);

  always_comb begin
    nxt       = cur;
    res_valid = 1'b0;
    res       = '{frame_byte: '0, frame_start: 1'b0, frame_last: 1'b0, status: ST_FRAME};

    if (cur.in_payload) begin
      res_valid = 1'b1;
      if (beat.end_of_data) begin
        nxt.in_payload       = 1'b0;
        nxt.payload_left     = '0;
        nxt.bad_header_count = '0;
        res.status           = ST_TRUNC;
      end else begin
        nxt.payload_left = left_dec;
        nxt.in_payload   = (left_dec != '0);
        res.frame_byte   = beat.data_byte;
        res.frame_last   = (cur.payload_left <= LEFT_BITS'(1));
      end
    end else if (beat.end_of_data) begin
      nxt.bad_header_count = '0;
      res_valid            = 1'b1;
      res.status           = ST_END;
    end else if (beat.data_byte == FILL_BYTE) begin
      // drop fill
    end else if (!beat.data_byte[2]) begin
      // bad quality bit: count, abandon at the limit
      if (count_inc >= limit_eff) begin
        nxt.bad_header_count = '0;
        res_valid            = 1'b1;
        res.status           = ST_ABANDON;
      end else begin
        nxt.bad_header_count = count_inc;
      end
    end else begin
      nxt.bad_header_count = '0;
      nxt.in_payload       = (len != '0);
      nxt.payload_left     = len;
      res_valid            = 1'b1;
      res.frame_byte       = beat.data_byte;
      res.frame_start      = 1'b1;
      res.frame_last       = (len == '0);
    end
  end

endmodule

`default_nettype wire
